### rtl/ffrs_pkg.sv
// ffrs_pkg: widths, character codes, line phases and the result bundle
// shared by the sequence-file statistics block.
// No dependencies.
package ffrs_pkg;

   localparam int LENGTH_WIDTH = 32;   // per-read length and quality countdown
   localparam int TOTAL_WIDTH  = 48;   // running sequence character total
   localparam int COUNT_WIDTH  = 32;   // record count
   localparam int WARN_WIDTH   = 16;   // header warning count

   localparam logic [7:0] CH_NL   = 8'd10;
   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_PLUS = 8'h2B;

   typedef enum logic [2:0] {
      PH_FIRST,    // waiting for the first byte of a file
      PH_HEADER,   // inside a header line
      PH_SEQ,      // sequence lines
      PH_QUAL,     // FASTQ quality lines
      PH_EXPECT    // next byte starts a FASTQ header
   } phase_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  read_count;
      logic [TOTAL_WIDTH-1:0]  nucleotide_total;
      logic [LENGTH_WIDTH-1:0] min_read_length;
      logic [LENGTH_WIDTH-1:0] max_read_length;
      logic                    is_fastq;
      logic [WARN_WIDTH-1:0]   warning_count;
   } stats_type;

endpackage

### rtl/ffrs_core.sv
// ffrs_core: parser state and statistics registers, updated once per
// transaction, with the end-of-file summary formed combinationally.
// Depends on ffrs_pkg.
module ffrs_core
   import ffrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,          // one transaction is consumed this cycle
   input  logic [7:0] data_byte,
   input  logic       byte_valid,
   input  logic       end_of_file,
   output stats_type  summary        // meaningful when step && end_of_file
);

   phase_type               phase_ff, phase_in, phase_mid;
   logic                    fastq_ff, fastq_in, fastq_mid;
   logic                    at_start_ff, at_start_in, at_start_mid;
   logic                    plus_ff, plus_in, plus_mid;
   logic [COUNT_WIDTH-1:0]  records_ff, records_in, records_mid;
   logic [TOTAL_WIDTH-1:0]  total_ff, total_in, total_mid;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in, length_mid;
   logic [LENGTH_WIDTH-1:0] qleft_ff, qleft_in, qleft_mid;
   logic [LENGTH_WIDTH-1:0] shortest_ff, shortest_in, shortest_mid;
   logic [LENGTH_WIDTH-1:0] longest_ff, longest_in, longest_mid;
   logic [WARN_WIDTH-1:0]   warn_ff, warn_in, warn_mid;

   logic                    take_byte;
   logic                    eof_step;
   logic                    is_nl;
   logic [1:0]              add_n;
   logic                    fin_byte;
   logic [TOTAL_WIDTH:0]    total_sum;
   logic [LENGTH_WIDTH:0]   length_sum;
   logic                    fin_eof;

   assign take_byte = step && byte_valid;
   assign eof_step  = step && end_of_file;
   assign is_nl     = (data_byte == CH_NL);

   // next line phase
   always_comb begin
      phase_mid = phase_ff;
      if (take_byte) begin
         unique case (phase_ff)
            PH_FIRST:  phase_mid = is_nl ? PH_SEQ : PH_HEADER;
            PH_HEADER: if (is_nl) phase_mid = PH_SEQ;
            PH_SEQ: begin
               if (is_nl) begin
                  if (plus_ff) phase_mid = PH_QUAL;
               end else if (at_start_ff && !fastq_ff && data_byte == CH_GT) begin
                  phase_mid = PH_HEADER;
               end
            end
            PH_QUAL: if (is_nl && qleft_ff == '0) phase_mid = PH_EXPECT;
            PH_EXPECT: phase_mid = is_nl ? PH_SEQ : PH_HEADER;
            default:   phase_mid = PH_FIRST;
         endcase
      end
      phase_in = eof_step ? PH_FIRST : phase_mid;
   end

   // datapath updates
   always_comb begin
      fastq_mid    = fastq_ff;
      at_start_mid = at_start_ff;
      plus_mid     = plus_ff;
      records_mid  = records_ff;
      qleft_mid    = qleft_ff;
      warn_mid     = warn_ff;
      add_n        = 2'd0;
      fin_byte     = 1'b0;
      if (take_byte) begin
         unique case (phase_ff)
            PH_FIRST: begin
               records_mid = COUNT_WIDTH'(1);
               fastq_mid   = (data_byte == CH_AT);
               if (is_nl) at_start_mid = 1'b1;
            end
            PH_HEADER: if (is_nl) at_start_mid = 1'b1;
            PH_SEQ: begin
               if (is_nl) begin
                  if (plus_ff) begin
                     plus_mid  = 1'b0;
                     qleft_mid = length_ff;
                  end
                  at_start_mid = 1'b1;
               end else if (at_start_ff) begin
                  at_start_mid = 1'b0;
                  if (!fastq_ff && data_byte == CH_GT) begin
                     records_mid = (records_ff == '1) ? records_ff : records_ff + 1'b1;
                     fin_byte    = 1'b1;
                  end else if (fastq_ff && data_byte == CH_PLUS) begin
                     plus_mid = 1'b1;
                  end else begin
                     add_n = 2'd1;
                  end
               end else if (plus_ff) begin
                  // '+' turned out to open a sequence line: count it too
                  plus_mid = 1'b0;
                  add_n    = 2'd2;
               end else begin
                  add_n = 2'd1;
               end
            end
            PH_QUAL: begin
               if (is_nl) begin
                  if (qleft_ff == '0) fin_byte = 1'b1;
               end else if (qleft_ff != '0) begin
                  qleft_mid = qleft_ff - 1'b1;
               end
            end
            PH_EXPECT: begin
               records_mid = (records_ff == '1) ? records_ff : records_ff + 1'b1;
               if (data_byte != CH_AT) begin
                  warn_mid = (warn_ff == '1) ? warn_ff : warn_ff + 1'b1;
               end
               if (is_nl) at_start_mid = 1'b1;
            end
            default: ;
         endcase
      end

      // saturating character adds
      total_sum  = {1'b0, total_ff} + {{(TOTAL_WIDTH-1){1'b0}}, add_n};
      length_sum = {1'b0, length_ff} + {{(LENGTH_WIDTH-1){1'b0}}, add_n};
      total_mid  = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];
      length_mid = length_sum[LENGTH_WIDTH] ? '1 : length_sum[LENGTH_WIDTH-1:0];

      shortest_mid = shortest_ff;
      longest_mid  = longest_ff;
      if (fin_byte) begin
         if (length_ff < shortest_ff) shortest_mid = length_ff;
         if (length_ff > longest_ff)  longest_mid  = length_ff;
         length_mid = '0;
      end

      // closing the last read at end of file
      fin_eof = eof_step && (phase_mid != PH_FIRST) &&
                (!fastq_mid || phase_mid == PH_QUAL || (phase_mid == PH_SEQ && plus_mid));

      summary.read_count       = records_mid;
      summary.nucleotide_total = total_mid;
      summary.min_read_length  = (fin_eof && length_mid < shortest_mid) ? length_mid
                                                                         : shortest_mid;
      summary.max_read_length  = (fin_eof && length_mid > longest_mid) ? length_mid
                                                                        : longest_mid;
      summary.is_fastq         = fastq_mid;
      summary.warning_count    = warn_mid;

      if (eof_step) begin
         fastq_in    = 1'b0;
         at_start_in = 1'b1;
         plus_in     = 1'b0;
         records_in  = '0;
         total_in    = '0;
         length_in   = '0;
         qleft_in    = '0;
         shortest_in = '1;
         longest_in  = '0;
         warn_in     = '0;
      end else begin
         fastq_in    = fastq_mid;
         at_start_in = at_start_mid;
         plus_in     = plus_mid;
         records_in  = records_mid;
         total_in    = total_mid;
         length_in   = length_mid;
         qleft_in    = qleft_mid;
         shortest_in = shortest_mid;
         longest_in  = longest_mid;
         warn_in     = warn_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         fastq_ff    <= 1'b0;
         at_start_ff <= 1'b1;
         plus_ff     <= 1'b0;
         records_ff  <= '0;
         total_ff    <= '0;
         length_ff   <= '0;
         qleft_ff    <= '0;
         shortest_ff <= '1;
         longest_ff  <= '0;
         warn_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         fastq_ff    <= fastq_in;
         at_start_ff <= at_start_in;
         plus_ff     <= plus_in;
         records_ff  <= records_in;
         total_ff    <= total_in;
         length_ff   <= length_in;
         qleft_ff    <= qleft_in;
         shortest_ff <= shortest_in;
         longest_ff  <= longest_in;
         warn_ff     <= warn_in;
      end
   end

   // a pending '+' only lives on a FASTQ sequence line
   a_plus_in_seq: assert property (@(posedge clock) disable iff (reset)
      plus_ff |-> (phase_ff == PH_SEQ && fastq_ff))
      else $error("plus pending outside FASTQ sequence phase");

   // before the first byte of a file nothing has been counted
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIRST) |-> (records_ff == '0 && total_ff == '0 && warn_ff == '0))
      else $error("counters not clear at start of file");

   // shortest never exceeds longest once any read has finished
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (shortest_ff <= longest_ff) || (shortest_ff == '1 && longest_ff == '0))
      else $error("shortest read longer than longest read");

endmodule

### rtl/fasta_fastq_read_statistics.sv
// fasta_fastq_read_statistics: top level with input register, parser core
// and result register.
// Depends on ffrs_pkg and ffrs_core.
//
// Streams a FASTA or FASTQ file one byte per transaction and returns one
// summary transaction (record count, total sequence characters, shortest and
// longest read, format flag, FASTQ header warnings) for each transaction that
// carries end_of_file; all statistics then clear so the next byte starts a new
// file. Throughput is one byte per clock when req_stall is low: a transaction
// is registered on acceptance in the input register and processed by the
// parser core when it is consumed from there. The summary is loaded into the
// result register when the end_of_file transaction is consumed, and rsp_valid
// rises with it. The only back-pressure comes from the result register: an
// end_of_file transaction waits in the input register (and req_stall rises)
// only while a previous summary is still held under rsp_stall.
module fasta_fastq_read_statistics
   import ffrs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // byte stream
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_byte_valid,
   input  logic                    req_end_of_file,
   // summary
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COUNT_WIDTH-1:0]  rsp_read_count,
   output logic [TOTAL_WIDTH-1:0]  rsp_nucleotide_total,
   output logic [LENGTH_WIDTH-1:0] rsp_min_read_length,
   output logic [LENGTH_WIDTH-1:0] rsp_max_read_length,
   output logic                    rsp_is_fastq,
   output logic [WARN_WIDTH-1:0]   rsp_warning_count
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_bvalid_ff;
   logic       in_eof_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   stats_type  out_stats_ff;

   stats_type  summary;
   logic       step;        // held transaction is consumed by the core
   logic       req_take;

   // a summary-producing transaction needs the result register free
   assign step      = in_valid_ff && (!in_eof_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) in_valid_in = req_valid;

      out_valid_in = out_valid_ff;
      if (step && in_eof_ff)  out_valid_in = 1'b1;
      else if (!rsp_stall)    out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_data_byte;
         in_bvalid_ff <= req_byte_valid;
         in_eof_ff    <= req_end_of_file;
      end
      if (step && in_eof_ff) out_stats_ff <= summary;
   end

   ffrs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .byte_valid  (in_bvalid_ff),
      .end_of_file (in_eof_ff),
      .summary     (summary)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_read_count       = out_stats_ff.read_count;
   assign rsp_nucleotide_total = out_stats_ff.nucleotide_total;
   assign rsp_min_read_length  = out_stats_ff.min_read_length;
   assign rsp_max_read_length  = out_stats_ff.max_read_length;
   assign rsp_is_fastq         = out_stats_ff.is_fastq;
   assign rsp_warning_count    = out_stats_ff.warning_count;

   // a new summary only follows a consumed end-of-file transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(step && in_eof_ff))
      else $error("summary appeared without end-of-file transaction");

   // the input side only stalls behind a blocked summary
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_eof_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked summary");

endmodule
